[hdl/cbps_pkg.sv]
`default_nettype none
package cbps_pkg;

  localparam int MAX_REF_POINTS = 1024;
  localparam int COORD_BITS     = 12;
  localparam int REF_IDX_W      = $clog2(MAX_REF_POINTS);
  localparam int REF_CNT_W      = $clog2(MAX_REF_POINTS + 1);
  localparam int SQ_W           = 2 * COORD_BITS;
  localparam int DIST_W         = SQ_W + 1;
  localparam int POINT_W        = 2 * COORD_BITS;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_CAND   = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [11:0] point_row;
    logic [11:0] point_col;
    logic [7:0]  cand_comp;
    logic [15:0] cand_index;
  } cbps_in_t;

  typedef struct packed {
    logic                 found;
    logic [DIST_W-1:0]    best_dist_sq;
    logic [REF_IDX_W-1:0] best_ref_index;
    logic [7:0]           best_comp;
    logic [15:0]          best_cand_index;
  } cbps_out_t;

endpackage
`default_nettype wire

[hdl/closest_boundary_pair_search_unit.sv]
`default_nettype none
// Closest pair search between a stored reference point set and candidate points.
// Input channel: a transaction is taken when start is high and busy is low.
//   action load   : stores the point as the next reference point (dropped
//                   when the store already holds MAX_REF_POINTS).
//   action cand   : compares the point with every stored reference point,
//                   one reference memory read per cycle; busy stays high until
//                   the last compare is done (not raised when none is stored).
//   action report : out_valid pulses for one cycle on the next cycle with the
//                   best pair and found flag, and the block is cleared.
//   action code 3 : ignored.
// The scan rate is set by the single read port of the reference memory.
// Result channel: out_valid marks out_item for exactly one cycle; the
// receiver cannot stall it, and report does not raise busy.
// Reset (rst_n low, synchronous) empties the reference set and the best pair;
// the reference memory itself is not cleared, only the count is.
module closest_boundary_pair_search_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire cbps_pkg::cbps_in_t in_item,
  output logic                    out_valid,
  output cbps_pkg::cbps_out_t     out_item
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [cbps_pkg::REF_CNT_W-1:0] ref_cnt_r, ref_cnt_nxt;
  logic [cbps_pkg::REF_CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic                           v1_r, v2_r;
  logic [cbps_pkg::REF_IDX_W-1:0] idx1_r, idx2_r;
  logic [cbps_pkg::SQ_W-1:0]      sqr_r, sqc_r;

  logic [cbps_pkg::COORD_BITS-1:0] cand_row_r, cand_col_r;
  logic [7:0]                      cand_comp_r;
  logic [15:0]                     cand_idx_r;

  logic                           have_best_r, have_best_nxt;
  logic [cbps_pkg::DIST_W-1:0]    best_dist_r, best_dist_nxt;
  logic [cbps_pkg::REF_IDX_W-1:0] best_ref_r, best_ref_nxt;
  logic [7:0]                     best_comp_r, best_comp_nxt;
  logic [15:0]                    best_cand_r, best_cand_nxt;

  logic                     out_valid_r;
  cbps_pkg::cbps_out_t      out_item_r;

  logic                            accept;
  logic                            do_load, do_cand, do_report;
  logic                            issue;
  logic [cbps_pkg::POINT_W-1:0]    rd_data;
  logic [cbps_pkg::COORD_BITS-1:0] ref_row, ref_col, dr, dc;
  logic [cbps_pkg::DIST_W-1:0]     dist_sq;
  logic                            better;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign do_load   = accept && (in_item.action == cbps_pkg::ACT_LOAD);
  assign do_cand   = accept && (in_item.action == cbps_pkg::ACT_CAND);
  assign do_report = accept && (in_item.action == cbps_pkg::ACT_REPORT);
  assign issue     = (state_r == ST_SCAN) && (rd_idx_r < ref_cnt_r);

  cbps_ram #(
    .WIDTH (cbps_pkg::POINT_W),
    .DEPTH (cbps_pkg::MAX_REF_POINTS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (do_load && (ref_cnt_r < cbps_pkg::REF_CNT_W'(cbps_pkg::MAX_REF_POINTS))),
    .waddr (ref_cnt_r[cbps_pkg::REF_IDX_W-1:0]),
    .wdata ({in_item.point_row[cbps_pkg::COORD_BITS-1:0],
             in_item.point_col[cbps_pkg::COORD_BITS-1:0]}),
    .re    (issue),
    .raddr (rd_idx_r[cbps_pkg::REF_IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign ref_row = rd_data[cbps_pkg::POINT_W-1:cbps_pkg::COORD_BITS];
  assign ref_col = rd_data[cbps_pkg::COORD_BITS-1:0];
  assign dr      = (ref_row > cand_row_r) ? ref_row - cand_row_r : cand_row_r - ref_row;
  assign dc      = (ref_col > cand_col_r) ? ref_col - cand_col_r : cand_col_r - ref_col;
  assign dist_sq = {1'b0, sqr_r} + {1'b0, sqc_r};

  always_comb begin
    better = 1'b0;
    if (!have_best_r || dist_sq < best_dist_r) begin
      better = 1'b1;
    end else if (dist_sq == best_dist_r) begin
      if (cand_comp_r != best_comp_r) begin
        better = cand_comp_r < best_comp_r;
      end else if (idx2_r != best_ref_r) begin
        better = idx2_r < best_ref_r;
      end else begin
        better = cand_idx_r < best_cand_r;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ref_cnt_nxt   = ref_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    have_best_nxt = have_best_r;
    best_dist_nxt = best_dist_r;
    best_ref_nxt  = best_ref_r;
    best_comp_nxt = best_comp_r;
    best_cand_nxt = best_cand_r;
    case (state_r)
      ST_IDLE: begin
        if (do_load && (ref_cnt_r < cbps_pkg::REF_CNT_W'(cbps_pkg::MAX_REF_POINTS))) begin
          ref_cnt_nxt = ref_cnt_r + cbps_pkg::REF_CNT_W'(1);
        end
        if (do_cand && (ref_cnt_r != '0)) begin
          state_nxt  = ST_SCAN;
          rd_idx_nxt = '0;
        end
        if (do_report) begin
          ref_cnt_nxt   = '0;
          rd_idx_nxt    = '0;
          have_best_nxt = 1'b0;
          best_dist_nxt = '1;
          best_ref_nxt  = '0;
          best_comp_nxt = '0;
          best_cand_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + cbps_pkg::REF_CNT_W'(1);
        end else if (!v1_r && !v2_r) begin
          state_nxt = ST_IDLE;
        end
        if (v2_r && better) begin
          have_best_nxt = 1'b1;
          best_dist_nxt = dist_sq;
          best_ref_nxt  = idx2_r;
          best_comp_nxt = cand_comp_r;
          best_cand_nxt = cand_idx_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_cnt_r   <= '0;
      rd_idx_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      have_best_r <= 1'b0;
      best_dist_r <= '1;
      best_ref_r  <= '0;
      best_comp_r <= '0;
      best_cand_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_cnt_r   <= ref_cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      have_best_r <= have_best_nxt;
      best_dist_r <= best_dist_nxt;
      best_ref_r  <= best_ref_nxt;
      best_comp_r <= best_comp_nxt;
      best_cand_r <= best_cand_nxt;
      out_valid_r <= do_report;
    end
  end

  always_ff @(posedge clk) begin
    if (do_cand) begin
      cand_row_r  <= in_item.point_row[cbps_pkg::COORD_BITS-1:0];
      cand_col_r  <= in_item.point_col[cbps_pkg::COORD_BITS-1:0];
      cand_comp_r <= in_item.cand_comp;
      cand_idx_r  <= in_item.cand_index;
    end
    idx1_r <= rd_idx_r[cbps_pkg::REF_IDX_W-1:0];
    idx2_r <= idx1_r;
    sqr_r  <= cbps_pkg::SQ_W'(dr) * cbps_pkg::SQ_W'(dr);
    sqc_r  <= cbps_pkg::SQ_W'(dc) * cbps_pkg::SQ_W'(dc);
    if (do_report) begin
      out_item_r.found           <= have_best_r;
      out_item_r.best_dist_sq    <= have_best_r ? best_dist_r : '0;
      out_item_r.best_ref_index  <= best_ref_r;
      out_item_r.best_comp       <= best_comp_r;
      out_item_r.best_cand_index <= best_cand_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_report_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_item.action == cbps_pkg::ACT_REPORT)))
    else $error("result without a report transaction");

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!have_best_r && (ref_cnt_r == '0) && (state_r == ST_IDLE)))
    else $error("block not cleared after report");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_idx_r <= ref_cnt_r) &&
    (ref_cnt_r <= cbps_pkg::REF_CNT_W'(cbps_pkg::MAX_REF_POINTS)))
    else $error("read index or reference count out of range");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == ST_SCAN) && $past(v1_r))
    else $error("compare stage active outside a scan");

  a_best_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(have_best_r) |-> $past(state_r == ST_SCAN && v2_r))
    else $error("best pair set outside a compare");

endmodule
`default_nettype wire

[hdl/cbps_ram.sv]
`default_nettype none
module cbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
